// ===== sv/shb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shb_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	localparam int Rounds = 80;

	// one queued word with its block tags
	typedef struct packed {
		logic [63:0] word;
		logic        first;
		logic        last;
		logic        eob;
	} shb_word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} shb_state_t;

	localparam logic [63:0] IV_TABLE [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] K_TABLE [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] big_sigma0(input logic [63:0] x);
		big_sigma0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] big_sigma1(input logic [63:0] x);
		big_sigma1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] small_sigma0(input logic [63:0] x);
		small_sigma0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
	endfunction

	function automatic logic [63:0] small_sigma1(input logic [63:0] x);
		small_sigma1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
	endfunction

endpackage

`default_nettype wire

// ===== sv/sha512_block_compression_core.sv =====
// Each block passes through loading of its sixteen words, the rounds and a final add; after the
// last block of a message the digest is emitted. One block is compressed at a time.
// The single round unit sets the pace; a four-word queue takes input during rounds.
// The eight digest words come out on consecutive cycles; the receiver cannot stall.
// arst_n clears control state and loads the chaining words with the initial hash values.
`timescale 1ns / 1ps
`default_nettype none

module sha512_block_compression_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] message_word,
	input  wire logic        first_block,
	input  wire logic        last_block,
	output logic             digest_valid,
	output logic [63:0]      digest_word,
	output logic [2:0]       digest_index,
	output logic             digest_last
);
	import shb_pkg::*;

	shb_word_t q_data;
	logic      q_valid;
	logic      q_pop;

	// accept and tag words
	shb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.message_word (message_word),
		.first_block  (first_block),
		.last_block   (last_block),
		.busy         (busy),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop)
	);

	// compress blocks and emit the digest
	shb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.digest_valid (digest_valid),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

endmodule

`default_nettype wire

// ===== sv/shb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shb_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [63:0]       message_word,
	input  wire logic              first_block,
	input  wire logic              last_block,
	output logic                   busy,
	output logic                   q_valid,
	output shb_pkg::shb_word_t     q_data,
	input  wire logic              q_pop
);
	import shb_pkg::*;

	shb_word_t         mem_q [QDepth];
	logic [QAw-1:0]    wr_ptr_q;
	logic [QAw-1:0]    rd_ptr_q;
	logic [QAw:0]      count_q;
	logic [3:0]        pos_q;
	logic              push;
	logic              pop;

	assign busy    = (count_q == (QAw+1)'(QDepth));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_data  = mem_q[rd_ptr_q];

	// tag the word and store it in the queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{word: message_word, first: first_block,
				last: last_block, eob: (pos_q == 4'd15)};
		end
	end

	// advance pointers, fill count and word position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAw'(1);
				pos_q    <= pos_q + 4'd1;
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAw'(1);
			if (push && !pop)
				count_q <= count_q + (QAw+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QAw+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ===== sv/shb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire shb_pkg::shb_word_t q_data,
	output logic                   q_pop,
	output logic                   digest_valid,
	output logic [63:0]            digest_word,
	output logic [2:0]             digest_index,
	output logic                   digest_last
);
	import shb_pkg::*;

	shb_state_t  state_q;
	shb_state_t  state_d;
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [6:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        first_q;
	logic        last_q;
	logic        emit_q;
	logic        first_any;
	logic        load_eob;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] ch;
	logic [63:0] maj;
	logic [63:0] w_new;
	logic [63:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;
	logic        out_valid_q;

	// round and schedule arithmetic
	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sigma1(v_q[4]) + ch + K_TABLE[rnd_q] + w_q[0];
		t2    = big_sigma0(v_q[0]) + maj;
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	assign first_any = first_q | q_data.first;
	assign load_eob  = (state_q == ST_LOAD) && q_valid && q_data.eob;

	// next state and queue pop
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				q_pop = q_valid;
				if (q_valid && q_data.eob)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == 7'(Rounds - 1))
					state_d = ST_FINAL;
			end
			ST_FINAL: begin
				state_d = emit_q ? ST_EMIT : ST_LOAD;
			end
			ST_EMIT: begin
				if (idx_q == 3'd7)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// hold state, chaining words and block flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rnd_q       <= '0;
			idx_q       <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= IV_TABLE[i];
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (q_data.eob) begin
							first_q <= 1'b0;
							last_q  <= 1'b0;
							emit_q  <= last_q | q_data.last;
							rnd_q   <= '0;
							if (first_any) begin
								for (int i = 0; i < 8; i++)
									h_q[i] <= IV_TABLE[i];
							end
						end else begin
							first_q <= first_any;
							last_q  <= last_q | q_data.last;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
				end
				ST_FINAL: begin
					idx_q <= '0;
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
				end
				ST_EMIT: begin
					idx_q <= idx_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// shift the schedule window and run the working words
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= q_data.word;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
		if (load_eob) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= first_any ? IV_TABLE[i] : h_q[i];
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == ST_EMIT) begin
			out_word_q <= h_q[idx_q];
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == 3'd7);
		end
	end

	assign digest_valid = out_valid_q;
	assign digest_word  = out_word_q;
	assign digest_index = out_idx_q;
	assign digest_last  = out_last_q;

endmodule

`default_nettype wire
